// ----- design/decfmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal field formatter package
// Types, character codes and the shift-and-add-three step used by the
// formatter.
// ----------------------------------------------------------------------------
package decfmt_pkg;

  localparam int ValueW    = 64;
  localparam int NumDigits = 20;
  localparam int BcdW      = 4 * NumDigits;
  localparam int DigCntW   = 5;
  localparam int BitCntW   = 6;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPlus  = 8'h2b;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_EMIT
  } state_t;

  typedef logic [BcdW-1:0] bcd_t;

  // Every decimal digit of five or more gets three added before the shift.
  function automatic bcd_t dabble_adjust(input bcd_t b);
    bcd_t r;
    r = b;
    for (int i = 0; i < NumDigits; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

// ----- design/decimal_integer_field_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// Decimal integer field formatter
// Prints one 64-bit integer as a padded decimal text field, one ASCII
// character per beat.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; value and the field
// options are sampled on that edge. The magnitude is converted to decimal one
// bit per cycle by a shift-and-add-three register, leading zero digits are
// then shifted out one digit per cycle, and the field is emitted one
// character per cycle, with at most MAX_FIELD_WIDTH characters per field.
// Each character is shown on out_char for a single cycle with strobe high;
// last marks the final one. The receiver cannot stall the block, so
// characters follow back to back. A new item may be started in the cycle
// that shows the last character. Synchronous reset returns the block to
// idle and drops strobe; no item is in flight after it.
// ----------------------------------------------------------------------------
module decimal_integer_field_formatter_unit #(
  parameter int MAX_FIELD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [63:0] value,
  input  logic        is_signed,
  input  logic [6:0]  width,
  input  logic [5:0]  precision,
  input  logic        left_align,
  input  logic        force_plus,
  input  logic        space_sign,
  output logic        strobe,
  output logic [7:0]  out_char,
  output logic        last
);
  import decfmt_pkg::*;

  localparam int CntW = $clog2(MAX_FIELD_WIDTH);

  state_t state, state_next;

  logic [ValueW-1:0]  mag, mag_next;
  bcd_t               bcd, bcd_next;
  bcd_t               bcd_adj;
  logic [BitCntW-1:0] bit_cnt, bit_cnt_next;
  logic [DigCntW-1:0] dig_cnt, dig_cnt_next;
  logic [6:0]         pad_cnt, pad_cnt_next;
  logic [5:0]         zero_cnt, zero_cnt_next;
  logic               sign_pend, sign_pend_next;
  logic [7:0]         sign_ch, sign_ch_next;
  logic               align, align_next;
  logic [5:0]         prec, prec_next;
  logic [6:0]         fld_width, fld_width_next;
  logic [CntW-1:0]    out_cnt, out_cnt_next;
  logic               strobe_next;
  logic [7:0]         out_char_next;
  logic               last_next;

  logic               accept;
  logic               conv_done;
  logic               norm_more;
  logic               emit_last;
  logic [5:0]         core;
  logic [6:0]         body;
  logic [7:0]         remaining;
  logic [7:0]         emit_char;

  assign accept    = start && (state == ST_IDLE);
  assign conv_done = (bit_cnt == BitCntW'(ValueW - 1));
  assign norm_more = (bcd[BcdW-1 -: 4] == 4'd0) && (dig_cnt > DigCntW'(1));
  assign remaining = 8'(pad_cnt) + 8'(sign_pend) + 8'(zero_cnt) + 8'(dig_cnt);
  assign emit_last = (remaining == 8'd1) || (out_cnt == CntW'(MAX_FIELD_WIDTH - 1));
  assign bcd_adj   = dabble_adjust(bcd);

  assign core = (prec > 6'(dig_cnt)) ? prec : 6'(dig_cnt);
  assign body = 7'(core) + 7'(sign_pend);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_next = ST_NORM;
      end
      ST_NORM: begin
        if (!norm_more) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    strobe_next = (state == ST_EMIT);
    last_next   = (state == ST_EMIT) && emit_last;
  end

  always_comb begin
    mag_next       = mag;
    bcd_next       = bcd;
    bit_cnt_next   = bit_cnt;
    dig_cnt_next   = dig_cnt;
    pad_cnt_next   = pad_cnt;
    zero_cnt_next  = zero_cnt;
    sign_pend_next = sign_pend;
    sign_ch_next   = sign_ch;
    align_next     = align;
    prec_next      = prec;
    fld_width_next = fld_width;
    out_cnt_next   = out_cnt;
    emit_char      = CharSpace;

    if (accept) begin
      mag_next       = (is_signed && value[63]) ? (ValueW'(0) - value) : value;
      bcd_next       = '0;
      bit_cnt_next   = '0;
      dig_cnt_next   = DigCntW'(NumDigits);
      align_next     = left_align;
      prec_next      = precision;
      fld_width_next = width;
      out_cnt_next   = '0;
      sign_pend_next = is_signed && (value[63] || force_plus || space_sign);
      if (value[63]) begin
        sign_ch_next = CharMinus;
      end else if (force_plus) begin
        sign_ch_next = CharPlus;
      end else begin
        sign_ch_next = CharSpace;
      end
    end

    if (state == ST_CONV) begin
      bcd_next     = {bcd_adj[BcdW-2:0], mag[ValueW-1]};
      mag_next     = {mag[ValueW-2:0], 1'b0};
      bit_cnt_next = bit_cnt + BitCntW'(1);
    end

    if (state == ST_NORM) begin
      if (norm_more) begin
        bcd_next     = {bcd[BcdW-5:0], 4'd0};
        dig_cnt_next = dig_cnt - DigCntW'(1);
      end else begin
        zero_cnt_next = core - 6'(dig_cnt);
        pad_cnt_next  = (fld_width > body) ? (fld_width - body) : 7'd0;
      end
    end

    if (state == ST_EMIT) begin
      out_cnt_next = out_cnt + CntW'(1);
      if (!align && (pad_cnt != 7'd0)) begin
        emit_char    = CharSpace;
        pad_cnt_next = pad_cnt - 7'd1;
      end else if (sign_pend) begin
        emit_char      = sign_ch;
        sign_pend_next = 1'b0;
      end else if (zero_cnt != 6'd0) begin
        emit_char     = CharZero;
        zero_cnt_next = zero_cnt - 6'd1;
      end else if (dig_cnt != '0) begin
        emit_char    = CharZero + 8'(bcd[BcdW-1 -: 4]);
        bcd_next     = {bcd[BcdW-5:0], 4'd0};
        dig_cnt_next = dig_cnt - DigCntW'(1);
      end else begin
        emit_char    = CharSpace;
        pad_cnt_next = pad_cnt - 7'd1;
      end
    end
    out_char_next = emit_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      last      <= 1'b0;
      sign_pend <= 1'b0;
      out_cnt   <= '0;
    end else begin
      state     <= state_next;
      strobe    <= strobe_next;
      last      <= last_next;
      sign_pend <= sign_pend_next;
      out_cnt   <= out_cnt_next;
    end
    mag       <= mag_next;
    bcd       <= bcd_next;
    bit_cnt   <= bit_cnt_next;
    dig_cnt   <= dig_cnt_next;
    pad_cnt   <= pad_cnt_next;
    zero_cnt  <= zero_cnt_next;
    sign_ch   <= sign_ch_next;
    align     <= align_next;
    prec      <= prec_next;
    fld_width <= fld_width_next;
    out_char  <= out_char_next;
  end

endmodule

// ----- design/decfmt_checker.sv -----
// ----------------------------------------------------------------------------
// Decimal field formatter checker
// Port-level properties of the formatter, attached to the formatter by bind.
// ----------------------------------------------------------------------------
module decfmt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last
);

  // A field is emitted without gaps until its last beat.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("field beats are not contiguous");

  // The beat after the last one of a field carries nothing.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("beat shown after the last of a field");

  // An accepted item keeps the block busy, and its first beat comes later.
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe))
    else $error("item accepted without the block turning busy");

  // Beats only follow a busy cycle.
  a_beat_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("beat shown while the block was idle");

endmodule

bind decimal_integer_field_formatter_unit decfmt_checker u_decfmt_checker (.*);
